/* sv/ngx_pkg.sv */
// ngx_pkg: shared types, register indexes, phase codes and fixed-point constants
// for the noise gate expander. Also holds the elaboration-time table builders
// (log table entries and exp root constants). No dependencies.
package ngx_pkg;

   typedef struct packed {
      logic en;
      logic accum;
   } mac_ctl_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOPE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYPASS    = 3'd5;

   localparam logic [1:0] PHASE_CLOSED  = 2'd0;
   localparam logic [1:0] PHASE_OPEN    = 2'd1;
   localparam logic [1:0] PHASE_HOLD    = 2'd2;
   localparam logic [1:0] PHASE_RELEASE = 2'd3;

   localparam longint DB_PER_OCT_Q16 = 101008905;
   localparam longint OCT_PER_DB_Q16 = 2786635;
   localparam longint ROUND_Q16      = 32768;
   localparam longint ROUND_Q30      = 536870912;
   localparam longint SMOOTH_KEEP    = 62259;
   localparam longint SMOOTH_TAKE    = 3277;

   localparam logic signed [15:0] DB_FLOOR   = -16'sd25600;
   localparam logic [14:0]        GR_CAP     = 15'd25600;
   localparam logic [16:0]        UNITY_GAIN = 17'd65536;
   localparam logic [30:0]        Q30_ONE    = 31'h4000_0000;

   localparam logic [15:0] THRESHOLD_RESET = 16'hD800;
   localparam logic [15:0] SLOPE_RESET     = 16'd32768;
   localparam logic [15:0] ATTACK_RESET    = 16'd65000;
   localparam logic [15:0] RELEASE_RESET   = 16'd65500;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (b > v) b = b >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] frac_log2(input logic [63:0] m_in);
      logic [63:0] m;
      logic [63:0] f;
      m = m_in;
      f = 64'd0;
      for (int k = 23; k >= 0; k--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            f[k] = 1'b1;
         end
      end
      return f;
   endfunction

   function automatic logic [15:0] log_entry(input int idx, input int depth_bits);
      logic [63:0] m;
      logic [63:0] f;
      logic [63:0] e;
      m = 64'h4000_0000 + ((64'(idx) << 30) >> depth_bits);
      f = frac_log2(m);
      e = (f * 64'(DB_PER_OCT_Q16) + (64'd1 << 39)) >> 40;
      return e[15:0];
   endfunction

   function automatic logic [30:0] exp_root(input int k);
      logic [63:0] r;
      r = isqrt64(64'd1 << 59);
      for (int j = 1; j <= k; j++) begin
         r = isqrt64(r << 30);
      end
      return r[30:0];
   endfunction

endpackage

/* sv/ngx_mac.sv */
// ngx_mac: the shared signed multiply-accumulate unit of the gate datapath.
// One product per cycle, optionally added to the held accumulator.
// Depends on ngx_pkg for the control struct.
module ngx_mac #(
   parameter int MUL_BITS = 32
) (
   input  logic                            clock,
   input  ngx_pkg::mac_ctl_type            mac_ctl,
   input  logic signed [MUL_BITS-1:0]      mul_a,
   input  logic signed [MUL_BITS-1:0]      mul_b,
   output logic signed [2*MUL_BITS-1:0]    acc
);
   logic signed [2*MUL_BITS-1:0] acc_ff;
   logic signed [2*MUL_BITS-1:0] acc_in;
   logic signed [2*MUL_BITS-1:0] prod;

   assign prod   = mul_a * mul_b;
   assign acc_in = mac_ctl.accum ? acc_ff + prod : prod;
   assign acc    = acc_ff;

   always_ff @(posedge clock) begin
      if (mac_ctl.en) acc_ff <= acc_in;
   end
endmodule

/* sv/noise_gate_expander_with_hold.sv */
// noise_gate_expander_with_hold: stereo noise gate / downward expander top level.
// Sequencer around one shared multiply-accumulate unit (ngx_mac).
// Depends on ngx_pkg for codes, constants and table builders.
//
// Usage:
//  req_ channel takes one stereo word (sample_left, sample_right) when req_valid
//  is high and req_stall is low. req_stall stays high while a word is in work.
//  rsp_ channel gives one word per input: gated samples, gate state and gain
//  reduction, held in an output register until rsp_stall is low.
//  csr_ channel writes a register by index (threshold, slope, attack, release,
//  hold, bypass); csr_ready is always high, write only while the block is idle.
//  The time from accept to rsp_valid varies with the normalize shifter of the two dB
//  conversions and the 16-step root product loop, all through the one multiplier.
//  Bypass words skip the datapath and go straight to the output step.
//  A new word is accepted while the previous result still waits on rsp_stall;
//  the finished word then waits in its last step until the output register frees.
//  Reset (synchronous, high) clears envelope, gain, gate phase and hold count and
//  loads the register defaults.
module noise_gate_expander_with_hold #(
   parameter int SAMPLE_BITS     = 24,
   parameter int LOG_TABLE_DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_right,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_right,
   output logic [1:0]                            rsp_gate_state,
   output logic [14:0]                           rsp_gain_reduction_db,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ngx_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ngx_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import ngx_pkg::*;

   localparam int SB       = SAMPLE_BITS;
   localparam int NB       = (SB > 17) ? SB : 17;
   localparam int NW       = NB + 1;
   localparam int MW       = (SB + 1 > 32) ? SB + 1 : 32;
   localparam int AW       = 2 * MW;
   localparam int LOG_BITS = $clog2(LOG_TABLE_DEPTH);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_ENV_A  = 5'd1;
   localparam logic [4:0] ST_ENV_B  = 5'd2;
   localparam logic [4:0] ST_ENV_W  = 5'd3;
   localparam logic [4:0] ST_NORM   = 5'd4;
   localparam logic [4:0] ST_DB_SUB = 5'd5;
   localparam logic [4:0] ST_GATE   = 5'd6;
   localparam logic [4:0] ST_RED_W  = 5'd7;
   localparam logic [4:0] ST_OCT    = 5'd8;
   localparam logic [4:0] ST_OCT_W  = 5'd9;
   localparam logic [4:0] ST_EXP    = 5'd10;
   localparam logic [4:0] ST_EXP_W  = 5'd11;
   localparam logic [4:0] ST_TGT    = 5'd12;
   localparam logic [4:0] ST_SM_A   = 5'd13;
   localparam logic [4:0] ST_SM_B   = 5'd14;
   localparam logic [4:0] ST_SM_W   = 5'd15;
   localparam logic [4:0] ST_APL_L  = 5'd16;
   localparam logic [4:0] ST_APL_LW = 5'd17;
   localparam logic [4:0] ST_APL_RW = 5'd18;
   localparam logic [4:0] ST_OUT    = 5'd19;

   // constant tables
   logic [15:0] log_tab [LOG_TABLE_DEPTH];
   logic [30:0] root_tab [16];

   for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_log
      assign log_tab[gi] = log_entry(gi, LOG_BITS);
   end
   for (genvar gk = 0; gk < 16; gk++) begin : g_root
      assign root_tab[gk] = exp_root(gk);
   end

   // configuration
   logic signed [15:0] thr_ff;
   logic [15:0]        slope_ff;
   logic [15:0]        attack_ff;
   logic [15:0]        release_ff;
   logic [16:0]        hold_cfg_ff;
   logic               bypass_ff;

   // sequencer and datapath
   logic [4:0]             state_ff, state_in;
   logic signed [SB-1:0]   xl_ff, xl_in, xr_ff, xr_in;
   logic [SB-1:0]          peak_ff, peak_in;
   logic [15:0]            c_ff, c_in;
   logic [SB-1:0]          env_ff, env_in;
   logic [NW-1:0]          nrm_ff, nrm_in;
   logic [5:0]             nsh_ff, nsh_in;
   logic                   db_sel_ff, db_sel_in;
   logic signed [15:0]     db_ff, db_in;
   logic [1:0]             phase_ff, phase_in;
   logic [16:0]            hold_ff, hold_in;
   logic [14:0]            r_ff, r_in;
   logic [4:0]             oct_n_ff, oct_n_in;
   logic [15:0]            frac_ff, frac_in;
   logic [3:0]             k_ff, k_in;
   logic [30:0]            g_ff, g_in;
   logic [16:0]            target_ff, target_in;
   logic [16:0]            gain_ff, gain_in;
   logic signed [SB-1:0]   outl_ff, outl_in, outr_ff, outr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]   rsp_l_ff, rsp_r_ff;
   logic [1:0]             rsp_state_ff;
   logic [14:0]            rsp_gr_ff;
   logic                   rsp_load;

   // shared unit
   mac_ctl_type            mac_ctl;
   logic signed [MW-1:0]   mac_a, mac_b;
   logic signed [AW-1:0]   acc;
   logic signed [AW-1:0]   acc_rnd16, acc_rnd30;

   ngx_mac #(.MUL_BITS(MW)) u_mac (
      .clock   (clock),
      .mac_ctl (mac_ctl),
      .mul_a   (mac_a),
      .mul_b   (mac_b),
      .acc     (acc)
   );

   assign acc_rnd16 = acc + AW'(ROUND_Q16);
   assign acc_rnd30 = acc + AW'(ROUND_Q30);

   // input magnitudes
   logic signed [SB:0] xl_ext, xr_ext, al_full, ar_full;
   logic [SB-1:0]      al, ar, peak_new;

   assign xl_ext   = (SB+1)'(req_sample_left);
   assign xr_ext   = (SB+1)'(req_sample_right);
   assign al_full  = (xl_ext < 0) ? -xl_ext : xl_ext;
   assign ar_full  = (xr_ext < 0) ? -xr_ext : xr_ext;
   assign al       = al_full[SB-1:0];
   assign ar       = ar_full[SB-1:0];
   assign peak_new = (al > ar) ? al : ar;

   // dB conversion helpers
   logic [5:0]          down;
   logic [LOG_BITS-1:0] log_idx;
   logic [16:0]         db_pen;
   logic signed [18:0]  db_raw;
   logic signed [15:0]  db_clamped;
   logic signed [16:0]  diff;
   logic [16:0]         r_raw;
   logic [20:0]         oct;
   logic [47:0]         tsum;
   logic [47:0]         tshift;

   assign down     = (nsh_ff == 6'd0) ? 6'd0 : nsh_ff - 6'd1;
   assign log_idx  = nrm_ff[NW-2 -: LOG_BITS];
   assign db_pen   = acc_rnd16[16 +: 17];
   assign db_raw   = $signed({3'b000, log_tab[log_idx]}) - $signed({2'b00, db_pen});
   assign db_clamped = (db_raw < 19'(DB_FLOOR)) ? DB_FLOOR :
                       (db_raw > 19'sd0) ? 16'sd0 : db_raw[15:0];
   assign diff     = 17'(thr_ff) - 17'(db_ff);
   assign r_raw    = acc_rnd16[16 +: 17];
   assign oct      = acc_rnd16[16 +: 21];
   assign tsum     = 48'(g_ff) + (48'd1 << (6'd13 + 6'(oct_n_ff)));
   assign tshift   = tsum >> (6'd14 + 6'(oct_n_ff));

   function automatic logic signed [SB-1:0] sat_sample(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] y;
      logic signed [AW-1:0] hi;
      logic signed [AW-1:0] lo;
      y  = v >>> 16;
      hi = (AW'(1) <<< (SB - 1)) - AW'(1);
      lo = -hi - AW'(1);
      if (y > hi) y = hi;
      if (y < lo) y = lo;
      return y[SB-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in  = state_ff;
      xl_in     = xl_ff;
      xr_in     = xr_ff;
      peak_in   = peak_ff;
      c_in      = c_ff;
      env_in    = env_ff;
      nrm_in    = nrm_ff;
      nsh_in    = nsh_ff;
      db_sel_in = db_sel_ff;
      db_in     = db_ff;
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      r_in      = r_ff;
      oct_n_in  = oct_n_ff;
      frac_in   = frac_ff;
      k_in      = k_ff;
      g_in      = g_ff;
      target_in = target_ff;
      gain_in   = gain_ff;
      outl_in   = outl_ff;
      outr_in   = outr_ff;
      rsp_load  = 1'b0;
      mac_ctl   = '0;
      mac_a     = '0;
      mac_b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xl_in   = req_sample_left;
               xr_in   = req_sample_right;
               peak_in = peak_new;
               c_in    = (peak_new > env_ff) ? attack_ff : release_ff;
               if (bypass_ff) begin
                  outl_in  = req_sample_left;
                  outr_in  = req_sample_right;
                  db_in    = 16'sd0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ENV_A;
               end
            end
         end
         ST_ENV_A: begin
            mac_ctl.en = 1'b1;
            mac_a      = MW'(env_ff);
            mac_b      = MW'(c_ff);
            state_in   = ST_ENV_B;
         end
         ST_ENV_B: begin
            mac_ctl.en    = 1'b1;
            mac_ctl.accum = 1'b1;
            mac_a         = MW'(peak_ff);
            mac_b         = MW'(UNITY_GAIN - 17'(c_ff));
            state_in      = ST_ENV_W;
         end
         ST_ENV_W: begin
            env_in    = acc_rnd16[16 +: SB];
            nrm_in    = NW'(acc_rnd16[16 +: SB]) << (NB - SB);
            nsh_in    = 6'd0;
            db_sel_in = 1'b0;
            state_in  = ST_NORM;
         end
         ST_NORM: begin
            if (nrm_ff == '0) begin
               db_in    = DB_FLOOR;
               state_in = db_sel_ff ? ST_OUT : ST_GATE;
            end else if (nrm_ff[NW-1]) begin
               mac_ctl.en = 1'b1;
               mac_a      = MW'(down);
               mac_b      = MW'(DB_PER_OCT_Q16);
               state_in   = ST_DB_SUB;
            end else if (nrm_ff[NW-1 -: 8] == 8'd0) begin
               nrm_in = nrm_ff << 8;
               nsh_in = nsh_ff + 6'd8;
            end else begin
               nrm_in = nrm_ff << 1;
               nsh_in = nsh_ff + 6'd1;
            end
         end
         ST_DB_SUB: begin
            db_in    = db_clamped;
            state_in = db_sel_ff ? ST_OUT : ST_GATE;
         end
         ST_GATE: begin
            mac_ctl.en = 1'b1;
            mac_a      = MW'(diff);
            mac_b      = MW'(slope_ff);
            if (db_ff >= thr_ff) begin
               phase_in = PHASE_OPEN;
               hold_in  = hold_cfg_ff;
            end else if (phase_ff == PHASE_OPEN || phase_ff == PHASE_HOLD) begin
               if (hold_ff != 17'd0) begin
                  phase_in = PHASE_HOLD;
                  hold_in  = hold_ff - 17'd1;
               end else begin
                  phase_in = PHASE_RELEASE;
               end
            end
            if (db_ff < thr_ff && phase_in != PHASE_HOLD) begin
               state_in = ST_RED_W;
            end else begin
               target_in = UNITY_GAIN;
               state_in  = ST_SM_A;
            end
         end
         ST_RED_W: begin
            r_in = (r_raw > 17'(GR_CAP)) ? GR_CAP : r_raw[14:0];
            if (r_raw == 17'd0) begin
               target_in = UNITY_GAIN;
               state_in  = ST_SM_A;
            end else begin
               state_in = ST_OCT;
            end
         end
         ST_OCT: begin
            mac_ctl.en = 1'b1;
            mac_a      = MW'(r_ff);
            mac_b      = MW'(OCT_PER_DB_Q16);
            state_in   = ST_OCT_W;
         end
         ST_OCT_W: begin
            oct_n_in = oct[20:16];
            frac_in  = oct[15:0];
            g_in     = Q30_ONE;
            k_in     = 4'd0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            if (frac_ff[15]) begin
               mac_ctl.en = 1'b1;
               mac_a      = MW'(g_ff);
               mac_b      = MW'(root_tab[k_ff]);
               state_in   = ST_EXP_W;
            end else begin
               frac_in = frac_ff << 1;
               k_in    = k_ff + 4'd1;
               if (k_ff == 4'd15) state_in = ST_TGT;
            end
         end
         ST_EXP_W: begin
            g_in    = acc_rnd30[30 +: 31];
            frac_in = frac_ff << 1;
            k_in    = k_ff + 4'd1;
            state_in = (k_ff == 4'd15) ? ST_TGT : ST_EXP;
         end
         ST_TGT: begin
            target_in = tshift[16:0];
            state_in  = ST_SM_A;
         end
         ST_SM_A: begin
            mac_ctl.en = 1'b1;
            mac_a      = MW'(gain_ff);
            mac_b      = MW'(SMOOTH_KEEP);
            state_in   = ST_SM_B;
         end
         ST_SM_B: begin
            mac_ctl.en    = 1'b1;
            mac_ctl.accum = 1'b1;
            mac_a         = MW'(target_ff);
            mac_b         = MW'(SMOOTH_TAKE);
            state_in      = ST_SM_W;
         end
         ST_SM_W: begin
            gain_in  = acc_rnd16[16 +: 17];
            state_in = ST_APL_L;
         end
         ST_APL_L: begin
            mac_ctl.en = 1'b1;
            mac_a      = MW'(xl_ff);
            mac_b      = MW'(gain_ff);
            state_in   = ST_APL_LW;
         end
         ST_APL_LW: begin
            outl_in    = sat_sample(acc_rnd16);
            mac_ctl.en = 1'b1;
            mac_a      = MW'(xr_ff);
            mac_b      = MW'(gain_ff);
            state_in   = ST_APL_RW;
         end
         ST_APL_RW: begin
            outr_in   = sat_sample(acc_rnd16);
            nrm_in    = NW'(gain_ff) << (NB - 17);
            nsh_in    = 6'd0;
            db_sel_in = 1'b1;
            state_in  = ST_NORM;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         env_ff       <= '0;
         gain_ff      <= '0;
         phase_ff     <= PHASE_CLOSED;
         hold_ff      <= '0;
         thr_ff       <= THRESHOLD_RESET;
         slope_ff     <= SLOPE_RESET;
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         hold_cfg_ff  <= '0;
         bypass_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff      <= csr_data[15:0];
               CSR_SLOPE:     slope_ff    <= csr_data[15:0];
               CSR_ATTACK:    attack_ff   <= csr_data[15:0];
               CSR_RELEASE:   release_ff  <= csr_data[15:0];
               CSR_HOLD:      hold_cfg_ff <= csr_data;
               CSR_BYPASS:    bypass_ff   <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      xl_ff     <= xl_in;
      xr_ff     <= xr_in;
      peak_ff   <= peak_in;
      c_ff      <= c_in;
      nrm_ff    <= nrm_in;
      nsh_ff    <= nsh_in;
      db_sel_ff <= db_sel_in;
      db_ff     <= db_in;
      r_ff      <= r_in;
      oct_n_ff  <= oct_n_in;
      frac_ff   <= frac_in;
      k_ff      <= k_in;
      g_ff      <= g_in;
      target_ff <= target_in;
      outl_ff   <= outl_in;
      outr_ff   <= outr_in;
      if (rsp_load) begin
         rsp_l_ff     <= outl_ff;
         rsp_r_ff     <= outr_ff;
         rsp_state_ff <= phase_ff;
         rsp_gr_ff    <= 15'(-db_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_left          = rsp_l_ff;
   assign rsp_out_right         = rsp_r_ff;
   assign rsp_gate_state        = rsp_state_ff;
   assign rsp_gain_reduction_db = rsp_gr_ff;
endmodule

/* verif/noise_gate_expander_with_hold_tb.sv */
// noise_gate_expander_with_hold_tb: self-checking bench for the stereo noise gate,
// with a bit-exact predictor of envelope, dB conversion, gate phases and gain.
// Depends on ngx_pkg and the noise_gate_expander_with_hold RTL.
`timescale 1ns / 1ps
module noise_gate_expander_with_hold_tb;
   import ngx_pkg::*;

   typedef struct {
      logic [23:0] left;
      logic [23:0] right;
      logic [1:0]  phase;
      logic [14:0] reduction;
   } gated_word_type;

   typedef struct {
      logic [23:0] left;
      logic [23:0] right;
      bit          known;
      logic [23:0] exp_left;
      logic [23:0] exp_right;
      logic [1:0]  exp_phase;
      logic [14:0] exp_reduction;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_sample_left = '0;
   logic signed [23:0] req_sample_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_out_left;
   logic signed [23:0] rsp_out_right;
   logic [1:0] rsp_gate_state;
   logic [14:0] rsp_gain_reduction_db;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   noise_gate_expander_with_hold uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and registers
   logic [15:0] thr_reg, slope_reg, att_reg, rel_reg;
   logic [16:0] hold_reg;
   logic        bypass_reg;
   longint unsigned env_lvl;
   longint unsigned gain_q16;
   logic [1:0]  phase_q;
   longint unsigned hold_left;
   longint unsigned log_lut[256];
   longint unsigned root_lut[16];

   gated_word_type pending_words[$];
   int  mismatches = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   int  quiet_cycles = 0;
   bit  timed_out = 0;

   function automatic longint db_of(longint unsigned v, int fs);
      int p;
      longint unsigned mant, idx;
      longint db;
      int down;
      if (v == 0) return -25600;
      p = 63;
      while (!v[p]) p--;
      mant = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
      idx = ((mant - 64'h4000_0000) * 256) >> 30;
      if (idx > 255) idx = 255;
      down = fs - p;
      if (down < 0) down = 0;
      db = longint'(log_lut[idx])
         - longint'((longint'(down) * DB_PER_OCT_Q16 + ROUND_Q16) >>> 16);
      if (db < -25600) db = -25600;
      if (db > 0) db = 0;
      return db;
   endfunction

   function automatic longint unsigned linear_gain(longint unsigned r);
      longint unsigned oct, g, n, f;
      if (r == 0) return 65536;
      oct = (r * OCT_PER_DB_Q16 + ROUND_Q16) >> 16;
      n = oct >> 16;
      f = oct & 16'hFFFF;
      g = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
         if (f[15-k]) g = (g * root_lut[k] + (64'd1 << 29)) >> 30;
      if (n > 40) return 0;
      return (g + (64'd1 << (13 + n))) >> (14 + n);
   endfunction

   function automatic logic [23:0] scaled_sample(longint x, longint unsigned g);
      longint p, y;
      p = x * longint'(g) + 32768;
      if (p >= 0) y = p / 65536;
      else y = -((-p + 65535) / 65536);
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[23:0];
   endfunction

   function automatic gated_word_type gate_sample(logic [23:0] l, logic [23:0] r);
      gated_word_type w;
      longint xl, xr, db, thr;
      longint unsigned peak, c, rr, target;
      xl = longint'($signed(l));
      xr = longint'($signed(r));
      peak = (xl < 0 ? -xl : xl);
      if ((xr < 0 ? -xr : xr) > peak) peak = (xr < 0 ? -xr : xr);
      thr = longint'($signed(thr_reg));
      if (bypass_reg) begin
         w.left = l; w.right = r; w.phase = phase_q; w.reduction = '0;
         return w;
      end
      c = (peak > env_lvl) ? att_reg : rel_reg;
      env_lvl = (c * env_lvl + (65536 - c) * peak + 32768) >> 16;
      db = db_of(env_lvl, 23);
      if (db >= thr) begin
         phase_q = PHASE_OPEN;
         hold_left = hold_reg;
      end else if (phase_q == PHASE_OPEN || phase_q == PHASE_HOLD) begin
         if (hold_left > 0) begin
            phase_q = PHASE_HOLD;
            hold_left--;
         end else phase_q = PHASE_RELEASE;
      end
      target = 65536;
      if (db < thr && phase_q != PHASE_HOLD) begin
         rr = (unsigned'(thr - db) * slope_reg + 32768) >> 16;
         if (rr > 25600) rr = 25600;
         target = linear_gain(rr);
      end
      gain_q16 = (SMOOTH_KEEP * gain_q16 + SMOOTH_TAKE * target + 32768) >> 16;
      w.left = scaled_sample(xl, gain_q16);
      w.right = scaled_sample(xr, gain_q16);
      w.phase = phase_q;
      w.reduction = 15'(-db_of(gain_q16, 16));
      return w;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   initial begin
      longint unsigned m, f;
      for (int i = 0; i < 256; i++) begin
         m = 64'h4000_0000 + ((64'(i) << 30) / 256);
         f = 0;
         for (int k = 23; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
               m >>= 1;
               f[k] = 1'b1;
            end
         end
         log_lut[i] = (f * DB_PER_OCT_Q16 + (64'd1 << 39)) >> 40;
      end
      root_lut[0] = int_sqrt(64'd1 << 59);
      for (int i = 1; i < 16; i++) root_lut[i] = int_sqrt(root_lut[i-1] << 30);
      thr_reg = THRESHOLD_RESET; slope_reg = SLOPE_RESET;
      att_reg = ATTACK_RESET; rel_reg = RELEASE_RESET;
      hold_reg = '0; bypass_reg = 1'b0;
      env_lvl = 0; gain_q16 = 0; phase_q = PHASE_CLOSED; hold_left = 0;
   end

   // result side: random stall and checking
   always @(posedge clock) begin
      gated_word_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h %h", rsp_out_left,
                                              rsp_out_right);
            end else begin
               e = pending_words.pop_front();
               if (rsp_out_left !== e.left || rsp_out_right !== e.right ||
                   rsp_gate_state !== e.phase || rsp_gain_reduction_db !== e.reduction) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %h %h %0d %0d got %h %h %0d %0d",
                              e.left, e.right, e.phase, e.reduction, rsp_out_left,
                              rsp_out_right, rsp_gate_state, rsp_gain_reduction_db);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000 && !timed_out) begin
         timed_out = 1;
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thr_reg = val[15:0];
         CSR_SLOPE:     slope_reg = val[15:0];
         CSR_ATTACK:    att_reg = val[15:0];
         CSR_RELEASE:   rel_reg = val[15:0];
         CSR_HOLD:      hold_reg = val;
         CSR_BYPASS:    bypass_reg = val[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_word(logic [23:0] l, logic [23:0] r, bit known, gated_word_type kw);
      gated_word_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_left <= l;
      req_sample_right <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = gate_sample(l, r);
      if (known) w = kw;
      pending_words.push_back(w);
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
   endtask

   function automatic logic [23:0] rand_sample(int lvl);
      logic [23:0] s;
      case (lvl)
         0: s = 24'($urandom);
         1: s = 24'($signed(12'($urandom)));
         2: s = 24'($signed(5'($urandom)));
         default: s = ($urandom_range(1)) ? 24'h800000 : 24'h7FFFFF;
      endcase
      return s;
   endfunction

   stim_row_type directed[$];

   initial begin
      gated_word_type kw;
      stim_row_type row;
      int lvl;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bypass rows with values readable at a glance
      write_reg(CSR_BYPASS, 17'd1);
      directed.push_back('{24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000,
                           PHASE_CLOSED, 15'd0});
      directed.push_back('{24'h000000, 24'h000001, 1, 24'h000000, 24'h000001,
                           PHASE_CLOSED, 15'd0});
      foreach (directed[i]) begin
         row = directed[i];
         kw = '{row.exp_left, row.exp_right, row.exp_phase, row.exp_reduction};
         send_word(row.left, row.right, 1, kw);
      end
      idle_input();
      drain();
      directed.delete();
      write_reg(CSR_BYPASS, 17'd0);
      write_reg(CSR_HOLD, 17'd3);
      directed.push_back('{24'h000000, 24'h000000, 0, '0, '0, '0, '0});
      directed.push_back('{24'h800000, 24'h800000, 0, '0, '0, '0, '0});
      directed.push_back('{24'h7FFFFF, 24'h800000, 0, '0, '0, '0, '0});
      for (int i = 0; i < 6; i++)
         directed.push_back('{24'h000003, 24'hFFFFFD, 0, '0, '0, '0, '0});
      directed.push_back('{24'h400000, 24'h000000, 0, '0, '0, '0, '0});
      for (int i = 0; i < 6; i++)
         directed.push_back('{24'h000000, 24'h000001, 0, '0, '0, '0, '0});
      foreach (directed[i])
         send_word(directed[i].left, directed[i].right, 0, kw);
      idle_input();
      drain();

      // random phases over several register settings
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin
            send_idle_pct = 48; recv_idle_pct = 13;
         end else if (ph == 8) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (ph == 0) begin
            send_idle_pct = 13; recv_idle_pct = 48;
         end
         case (ph % 4)
            0: begin
               write_reg(CSR_THRESHOLD, 17'(16'(-20480)));
               write_reg(CSR_SLOPE, 17'd62259);
               write_reg(CSR_ATTACK, 17'd0);
               write_reg(CSR_RELEASE, 17'd65535);
               write_reg(CSR_HOLD, 17'd131071);
            end
            1: begin
               write_reg(CSR_THRESHOLD, 17'd0);
               write_reg(CSR_SLOPE, 17'd0);
               write_reg(CSR_ATTACK, 17'd65535);
               write_reg(CSR_RELEASE, 17'd0);
               write_reg(CSR_HOLD, 17'd0);
            end
            2: begin
               write_reg(CSR_THRESHOLD, 17'(16'($urandom)));
               write_reg(CSR_SLOPE, 17'(16'($urandom)));
               write_reg(CSR_ATTACK, 17'($urandom_range(65535, 60000)));
               write_reg(CSR_RELEASE, 17'($urandom_range(65535, 60000)));
               write_reg(CSR_HOLD, 17'($urandom_range(20)));
            end
            default: begin
               write_reg(CSR_THRESHOLD, 17'(16'(-$urandom_range(20480))));
               write_reg(CSR_SLOPE, 17'($urandom_range(62259)));
               write_reg(CSR_ATTACK, 17'($urandom_range(65535)));
               write_reg(CSR_RELEASE, 17'($urandom_range(65535)));
               write_reg(CSR_HOLD, 17'($urandom_range(8)));
               write_reg(CSR_BYPASS, 17'(ph == 7));
            end
         endcase
         for (int i = 0; i < 92; i++) begin
            if (i % 23 == 0) lvl = $urandom_range(3);
            send_word(rand_sample(lvl), rand_sample(lvl), 0, kw);
         end
         idle_input();
         drain();
         if (ph == 7) write_reg(CSR_BYPASS, 17'd0);
      end

      if (mismatches == 0 && pending_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
